/* design/rspr_pkg.sv */
package rspr_pkg;

  localparam int UA_W = 41;
  localparam int UX_W = 66;
  localparam int UR_W = 42;
  localparam int PROD_W = UR_W + 34;

  localparam logic [1:0] OP_MUL  = 2'd0;
  localparam logic [1:0] OP_DIV  = 2'd1;
  localparam logic [1:0] OP_SQRT = 2'd2;

  localparam logic [5:0] LEN_MUL  = 6'd34;
  localparam logic [5:0] LEN_DIV  = 6'd48;
  localparam logic [5:0] LEN_SQRT = 6'd33;

  localparam logic [1:0] REG_STRENGTH   = 2'd0;
  localparam logic [1:0] REG_NEIGHBOR   = 2'd1;
  localparam logic [1:0] REG_YIELD      = 2'd2;
  localparam logic [1:0] REG_PLASTICITY = 2'd3;

  localparam logic [15:0] RST_STRENGTH   = 16'd19661;
  localparam logic [31:0] RST_NEIGHBOR   = 32'd655360;
  localparam logic [15:0] RST_YIELD      = 16'd655;
  localparam logic [15:0] RST_PLASTICITY = 16'd19661;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } rspr_ctl_t;

  function automatic logic [31:0] sat32(input logic [43:0] v);
    if (!v[43] && (v[42:31] != 12'h000)) begin
      return 32'h7fff_ffff;
    end
    if (v[43] && (v[42:31] != 12'hfff)) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

/* design/rspr_ram.sv */
module rspr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                       clk_i,
  input  logic                                       we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                           wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                           rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

/* design/rspr_alu.sv */
module rspr_alu (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rspr_pkg::rspr_ctl_t             ctl_i,
  input  logic [rspr_pkg::UA_W-1:0]       a_i,
  input  logic [rspr_pkg::UX_W-1:0]       x_i,
  output logic                            done_o,
  output logic [rspr_pkg::PROD_W-1:0]     prod_o,
  output logic [47:0]                     quo_o,
  output logic [32:0]                     root_o
);

  logic [rspr_pkg::UR_W-1:0] r_q, r_d;
  logic [rspr_pkg::UX_W-1:0] x_q, x_d;
  logic [rspr_pkg::UA_W-1:0] y_q, y_d;
  logic [1:0]                op_q;
  logic [5:0]                cnt_q;
  logic                      busy_q;
  logic                      done_q;
  logic [rspr_pkg::UR_W-1:0] op1, op2;
  logic                      sub;
  logic [rspr_pkg::UR_W:0]   sum;
  logic                      ok;
  logic [5:0]                len;

  always_comb begin
    case (op_q)
      rspr_pkg::OP_MUL: begin
        op1 = r_q;
        op2 = x_q[0] ? {1'b0, y_q} : '0;
        sub = 1'b0;
      end
      rspr_pkg::OP_DIV: begin
        op1 = {r_q[rspr_pkg::UR_W-2:0], x_q[rspr_pkg::UX_W-1]};
        op2 = {1'b0, y_q};
        sub = 1'b1;
      end
      default: begin
        op1 = {r_q[rspr_pkg::UR_W-3:0], x_q[rspr_pkg::UX_W-1 -: 2]};
        op2 = {y_q[rspr_pkg::UA_W-2:0], 2'b01};
        sub = 1'b1;
      end
    endcase
    sum = {1'b0, op1} + ({1'b0, op2} ^ {(rspr_pkg::UR_W+1){sub}})
        + {{rspr_pkg::UR_W{1'b0}}, sub};
    ok = !sum[rspr_pkg::UR_W];
  end

  always_comb begin
    r_d = r_q;
    x_d = x_q;
    y_d = y_q;
    case (op_q)
      rspr_pkg::OP_MUL: begin
        r_d = sum[rspr_pkg::UR_W:1];
        x_d = {sum[0], x_q[rspr_pkg::UX_W-1:1]};
      end
      rspr_pkg::OP_DIV: begin
        r_d = ok ? sum[rspr_pkg::UR_W-1:0] : op1;
        x_d = {x_q[rspr_pkg::UX_W-2:0], ok};
      end
      default: begin
        r_d = ok ? sum[rspr_pkg::UR_W-1:0] : op1;
        x_d = {x_q[rspr_pkg::UX_W-3:0], 2'b00};
        y_d = {y_q[rspr_pkg::UA_W-2:0], ok};
      end
    endcase
  end

  always_comb begin
    case (ctl_i.op)
      rspr_pkg::OP_MUL: len = rspr_pkg::LEN_MUL;
      rspr_pkg::OP_DIV: len = rspr_pkg::LEN_DIV;
      default:          len = rspr_pkg::LEN_SQRT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= rspr_pkg::OP_MUL;
    end else begin
      done_q <= busy_q && (cnt_q == 6'd1);
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= len;
        op_q   <= ctl_i.op;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      r_q <= '0;
      x_q <= x_i;
      y_q <= (ctl_i.op == rspr_pkg::OP_SQRT) ? '0 : a_i;
    end else if (busy_q) begin
      r_q <= r_d;
      x_q <= x_d;
      y_q <= y_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = {r_q, x_q[rspr_pkg::UX_W-1 -: 34]};
  assign quo_o  = x_q[47:0];
  assign root_o = y_q[32:0];

endmodule

/* design/plastic_spring_relaxation_core.sv */
// Channel   Direction  Beat when                       Payload
// in        sink       in_valid_i & in_ready_o         spring_index, fresh, two positions
// out       source     out_valid_o & out_ready_i       spring_id, new positions, rest, flag
// apb       slave      psel & penable & pwrite         four registers, zero wait states
// A spring runs from its input beat to its result beat through the single shared shift-add unit,
// which runs up to eight multiplies, one square root and three divides in turn, and fewer when
// the particles coincide.
// The rest length table is a RAM that holds nothing valid until a spring is written.
// Reset clears the sequencer and loads the register defaults; the output register
// holds a beat under back-pressure while the next spring is already accepted.
module plastic_spring_relaxation_core #(
  parameter int MAX_SPRINGS = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [9:0]         spring_index_i,
  input  logic               fresh_i,
  input  logic signed [31:0] pos_a_x_i,
  input  logic signed [31:0] pos_a_y_i,
  input  logic signed [31:0] pos_b_x_i,
  input  logic signed [31:0] pos_b_y_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [9:0]         spring_id_o,
  output logic signed [31:0] new_a_x_o,
  output logic signed [31:0] new_a_y_o,
  output logic signed [31:0] new_b_x_o,
  output logic signed [31:0] new_b_y_o,
  output logic [31:0]        new_rest_o,
  output logic               coincident_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = (MAX_SPRINGS > 1) ? $clog2(MAX_SPRINGS) : 1;
  localparam int RW = $clog2(MAX_SPRINGS + 1) + 10;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_SQRT  = 4'd3;
  localparam logic [3:0] S_YLD   = 4'd4;
  localparam logic [3:0] S_PLS   = 4'd5;
  localparam logic [3:0] S_DIVQ  = 4'd6;
  localparam logic [3:0] S_MULG  = 4'd7;
  localparam logic [3:0] S_MULM  = 4'd8;
  localparam logic [3:0] S_DIVUX = 4'd9;
  localparam logic [3:0] S_DIVUY = 4'd10;
  localparam logic [3:0] S_MULHX = 4'd11;
  localparam logic [3:0] S_MULHY = 4'd12;
  localparam logic [3:0] S_OUT   = 4'd13;

  logic [15:0] strength_q, yield_q, plast_q;
  logic [31:0] neigh_q;

  logic [3:0]  state_q, state_d, nxt;
  logic        issued_q, issued_d;
  logic        out_valid_q;
  logic        in_beat, load_out;

  logic [9:0]  idx_q, idx_red_q;
  logic [3:0]  red_k_q;
  logic [3:0]  red_k;
  logic [RW-1:0] red_lim;
  logic        fresh_q;
  logic [31:0] ax_q, ay_q, bx_q, by_q;
  logic [32:0] dx_q, dy_q;
  logic [32:0] ndx, ndy;
  logic [31:0] adx, ady;
  logic [64:0] sq_q;
  logic [32:0] dist_q;
  logic [31:0] rest_q;
  logic        up_q, dn_q;
  logic [33:0] diff_q;
  logic [32:0] af_q;
  logic        fneg_q;
  logic [32:0] ag_q;
  logic        gneg_q;
  logic [33:0] ae_q;
  logic        eneg_q;
  logic [40:0] am_q;
  logic        mneg_q;
  logic [16:0] uxm_q, uym_q;
  logic [42:0] hx_q, hy_q;
  logic [31:0] hdiv;

  rspr_pkg::rspr_ctl_t             u_ctl;
  logic                            u_start;
  logic [1:0]                      u_op;
  logic [rspr_pkg::UA_W-1:0]       u_a;
  logic [rspr_pkg::UX_W-1:0]       u_x;
  logic                            u_done;
  logic [rspr_pkg::PROD_W-1:0]     u_prod;
  logic [47:0]                     u_quo;
  logic [32:0]                     u_root;

  logic        ram_we;
  logic [31:0] ram_rdata;

  logic [31:0] c_d;
  logic [32:0] c_rpd;
  logic        c_up, c_dn;
  logic [33:0] c_delta;
  logic [34:0] c_inc;
  logic [31:0] c_rest;
  logic [32:0] c_qc;
  logic [48:0] c_pg;
  logic [59:0] c_sh;
  logic [57:0] c_ph;
  logic [40:0] c_hm;
  logic        c_hneg;
  logic [42:0] c_h;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strength_q <= rspr_pkg::RST_STRENGTH;
      neigh_q    <= rspr_pkg::RST_NEIGHBOR;
      yield_q    <= rspr_pkg::RST_YIELD;
      plast_q    <= rspr_pkg::RST_PLASTICITY;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        rspr_pkg::REG_STRENGTH: strength_q <= pwdata[15:0];
        rspr_pkg::REG_NEIGHBOR: neigh_q    <= pwdata;
        rspr_pkg::REG_YIELD:    yield_q    <= pwdata[15:0];
        default:                plast_q    <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rspr_pkg::REG_STRENGTH: prdata = {16'd0, strength_q};
      rspr_pkg::REG_NEIGHBOR: prdata = neigh_q;
      rspr_pkg::REG_YIELD:    prdata = {16'd0, yield_q};
      default:                prdata = {16'd0, plast_q};
    endcase
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign load_out   = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  assign ndx  = dx_q[32] ? (33'd0 - dx_q) : dx_q;
  assign ndy  = dy_q[32] ? (33'd0 - dy_q) : dy_q;
  assign adx  = ndx[31:0];
  assign ady  = ndy[31:0];
  assign hdiv = (neigh_q == 32'd0) ? 32'd1 : neigh_q;

  assign u_ctl = '{start: u_start, op: u_op};

  always_comb begin
    u_op = rspr_pkg::OP_MUL;
    u_a  = '0;
    u_x  = '0;
    case (state_q)
      S_SQX: begin
        u_a = 41'(adx);
        u_x = 66'(adx);
      end
      S_SQY: begin
        u_a = 41'(ady);
        u_x = 66'(ady);
      end
      S_SQRT: begin
        u_op = rspr_pkg::OP_SQRT;
        u_x  = {1'b0, sq_q};
      end
      S_YLD: begin
        u_a = 41'(rest_q);
        u_x = 66'(yield_q);
      end
      S_PLS: begin
        u_a = 41'(diff_q);
        u_x = 66'(plast_q);
      end
      S_DIVQ: begin
        u_op = rspr_pkg::OP_DIV;
        u_a  = 41'(hdiv);
        u_x  = {rest_q, 34'd0};
      end
      S_MULG: begin
        u_a = 41'(af_q);
        u_x = 66'(strength_q);
      end
      S_MULM: begin
        u_a = 41'(ag_q);
        u_x = 66'(ae_q);
      end
      S_DIVUX: begin
        u_op = rspr_pkg::OP_DIV;
        u_a  = 41'(dist_q);
        u_x  = {adx, 34'd0};
      end
      S_DIVUY: begin
        u_op = rspr_pkg::OP_DIV;
        u_a  = 41'(dist_q);
        u_x  = {ady, 34'd0};
      end
      S_MULHX: begin
        u_a = am_q;
        u_x = 66'(uxm_q);
      end
      S_MULHY: begin
        u_a = am_q;
        u_x = 66'(uym_q);
      end
      default: begin
        u_a = '0;
      end
    endcase
  end

  always_comb begin
    case (state_q)
      S_SQX:   nxt = S_SQY;
      S_SQY:   nxt = S_SQRT;
      S_SQRT:  nxt = S_YLD;
      S_YLD:   nxt = S_PLS;
      S_PLS:   nxt = S_DIVQ;
      S_DIVQ:  nxt = S_MULG;
      S_MULG:  nxt = (dist_q == 33'd0) ? S_OUT : S_MULM;
      S_MULM:  nxt = S_DIVUX;
      S_DIVUX: nxt = S_DIVUY;
      S_DIVUY: nxt = S_MULHX;
      S_MULHX: nxt = S_MULHY;
      default: nxt = S_OUT;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    issued_d = issued_q;
    u_start  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          state_d  = S_SQX;
          issued_d = 1'b0;
        end
      end
      S_OUT: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        if ((state_q == S_PLS) && !up_q && !dn_q) begin
          state_d = S_DIVQ;
        end else if (!issued_q) begin
          u_start  = 1'b1;
          issued_d = 1'b1;
        end else if (u_done) begin
          issued_d = 1'b0;
          state_d  = nxt;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
      red_k_q     <= '0;
    end else begin
      state_q  <= state_d;
      issued_q <= issued_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_beat) begin
        red_k_q <= 4'd10;
      end else if (red_k_q != 4'd0) begin
        red_k_q <= red_k;
      end
    end
  end

  assign red_k   = red_k_q - 4'd1;
  assign red_lim = RW'(MAX_SPRINGS) << red_k;

  always_comb begin
    c_d     = u_prod[47:16];
    c_rpd   = {1'b0, rest_q} + {1'b0, c_d};
    c_up    = {1'b0, dist_q} > {1'b0, c_rpd};
    c_dn    = ({1'b0, dist_q} + 34'(c_d)) < 34'(rest_q);
    c_delta = u_prod[49:16];
    c_inc   = 35'(rest_q) + 35'(c_delta);
    if (up_q) begin
      c_rest = (c_inc > 35'h0_ffff_ffff) ? 32'hffff_ffff : c_inc[31:0];
    end else begin
      c_rest = (c_delta > 34'(rest_q)) ? 32'd0 : (rest_q - c_delta[31:0]);
    end
    c_qc   = (u_quo > 48'h1_0000_0000) ? 33'h1_0000_0000 : u_quo[32:0];
    c_pg   = u_prod[48:0];
    c_sh   = u_prod[75:16];
    c_ph   = (state_q == S_MULHX) ? u_prod[57:0] : u_prod[57:0];
    c_hneg = mneg_q ^ ((state_q == S_MULHX) ? dx_q[32] : dy_q[32]);
    if (c_hneg && (c_ph != 58'd0)) begin
      c_hm = 41'((c_ph - 58'd1) >> 17) + 41'd1;
      c_h  = 43'd0 - 43'(c_hm);
    end else begin
      c_hm = 41'(c_ph >> 17);
      c_h  = 43'(c_hm);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      idx_q     <= spring_index_i;
      idx_red_q <= spring_index_i;
      fresh_q   <= fresh_i;
      ax_q      <= pos_a_x_i;
      ay_q      <= pos_a_y_i;
      bx_q      <= pos_b_x_i;
      by_q      <= pos_b_y_i;
      dx_q      <= {pos_b_x_i[31], pos_b_x_i} - {pos_a_x_i[31], pos_a_x_i};
      dy_q      <= {pos_b_y_i[31], pos_b_y_i} - {pos_a_y_i[31], pos_a_y_i};
      hx_q      <= '0;
      hy_q      <= '0;
    end else if ((red_k_q != 4'd0) && (RW'(idx_red_q) >= red_lim)) begin
      idx_red_q <= 10'(RW'(idx_red_q) - red_lim);
    end
    if (u_done) begin
      case (state_q)
        S_SQX: sq_q <= 65'(u_prod[63:0]);
        S_SQY: sq_q <= sq_q + u_prod[64:0];
        S_SQRT: begin
          dist_q <= u_root;
          rest_q <= fresh_q ? neigh_q : ram_rdata;
        end
        S_YLD: begin
          up_q <= c_up;
          dn_q <= c_dn && !c_up;
          if (c_up) begin
            diff_q <= {1'b0, dist_q} - {1'b0, c_rpd};
          end else begin
            diff_q <= 34'(rest_q) - 34'(c_d) - {1'b0, dist_q};
          end
        end
        S_PLS: rest_q <= c_rest;
        S_DIVQ: begin
          fneg_q <= c_qc > 33'h1_0000;
          af_q   <= (c_qc > 33'h1_0000) ? (c_qc - 33'h1_0000) : (33'h1_0000 - c_qc);
          eneg_q <= {1'b0, dist_q} > 34'(rest_q);
          ae_q   <= ({1'b0, dist_q} > 34'(rest_q)) ? ({1'b0, dist_q} - 34'(rest_q))
                                                  : (34'(rest_q) - {1'b0, dist_q});
        end
        S_MULG: begin
          gneg_q <= fneg_q && (c_pg != 49'd0);
          if (fneg_q && (c_pg != 49'd0)) begin
            ag_q <= 33'((c_pg - 49'd1) >> 16) + 33'd1;
          end else begin
            ag_q <= 33'(c_pg >> 16);
          end
        end
        S_MULM: begin
          mneg_q <= gneg_q ^ eneg_q;
          am_q   <= (c_sh > 60'h100_0000_0000) ? 41'h100_0000_0000 : c_sh[40:0];
        end
        S_DIVUX: uxm_q <= u_quo[16:0];
        S_DIVUY: uym_q <= u_quo[16:0];
        S_MULHX: hx_q <= c_h;
        S_MULHY: hy_q <= c_h;
        default: begin
          sq_q <= sq_q;
        end
      endcase
    end
    if (load_out) begin
      spring_id_o  <= idx_q;
      new_a_x_o    <= rspr_pkg::sat32({{12{ax_q[31]}}, ax_q} - {hx_q[42], hx_q});
      new_a_y_o    <= rspr_pkg::sat32({{12{ay_q[31]}}, ay_q} - {hy_q[42], hy_q});
      new_b_x_o    <= rspr_pkg::sat32({{12{bx_q[31]}}, bx_q} + {hx_q[42], hx_q});
      new_b_y_o    <= rspr_pkg::sat32({{12{by_q[31]}}, by_q} + {hy_q[42], hy_q});
      new_rest_o   <= rest_q;
      coincident_o <= (dist_q == 33'd0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign ram_we      = (state_q == S_DIVQ) && !issued_q;

  rspr_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (u_ctl),
    .a_i    (u_a),
    .x_i    (u_x),
    .done_o (u_done),
    .prod_o (u_prod),
    .quo_o  (u_quo),
    .root_o (u_root)
  );

  rspr_ram #(
    .WIDTH (32),
    .DEPTH (MAX_SPRINGS)
  ) u_rest_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(idx_red_q)),
    .wdata_i (rest_q),
    .raddr_i (AW'(idx_red_q)),
    .rdata_o (ram_rdata)
  );

endmodule

/* design/rspr_chk.sv */
module rspr_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [9:0]         spring_index_i,
  input logic               fresh_i,
  input logic signed [31:0] pos_a_x_i,
  input logic signed [31:0] pos_a_y_i,
  input logic signed [31:0] pos_b_x_i,
  input logic signed [31:0] pos_b_y_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [9:0]         spring_id_o,
  input logic signed [31:0] new_a_x_o,
  input logic signed [31:0] new_a_y_o,
  input logic signed [31:0] new_b_x_o,
  input logic signed [31:0] new_b_y_o,
  input logic [31:0]        new_rest_o,
  input logic               coincident_o,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [3:0]         paddr,
  input logic [31:0]        pwdata,
  input logic [31:0]        prdata,
  input logic               pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(new_rest_o)
      && $stable(new_a_x_o) && $stable(spring_id_o) && $stable(coincident_o))
    else $error("output beat changed while stalled");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken again while a spring is in work");

  a_result_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("result shown while the sequencer is still busy");

endmodule

bind plastic_spring_relaxation_core rspr_chk u_chk (.*);
